// ===== sv/jfbs_pkg.sv =====
// shared types and constants for the jpeg frame boundary scanner
package jfbs_pkg;

  // marker ranges on the upper half of the byte window
  localparam logic [15:0] MarkerLo    = 16'hFFC0;
  localparam logic [15:0] MarkerHi    = 16'hFFFE;
  localparam logic [15:0] SoiCode     = 16'hFFD8;
  localparam logic [15:0] NoLenLo     = 16'hFFD0;
  localparam logic [15:0] NoLenHi     = 16'hFFD9;
  // lower half of the window after an soi that opens a frame
  localparam logic [15:0] SoiNextLo   = 16'hFFC0;
  localparam logic [15:0] MaxSegReset = 16'hF000;

  // one input byte transfer
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_item_t;

  // one result transfer
  typedef struct packed {
    logic frame_boundary;
    logic in_frame;
    logic skipping;
  } out_item_t;

endpackage

// ===== sv/jfbs_state.sv =====
// scan state registers and per-byte next-state logic
module jfbs_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  jfbs_pkg::in_item_t item_i,
  input  logic [15:0]        max_seg_i,
  output jfbs_pkg::out_item_t result_o
);

  logic [31:0] window_q, window_d;
  logic        open_q, open_d;
  logic [15:0] skip_q, skip_d;

  logic [31:0] shifted;
  logic [15:0] hi, len, count;
  logic        is_marker, is_soi, has_len;
  logic        boundary, skipping;

  assign shifted   = {window_q[23:0], item_i.byte_in};
  assign hi        = shifted[31:16];
  assign len       = shifted[15:0];
  assign is_marker = (hi >= jfbs_pkg::MarkerLo) && (hi <= jfbs_pkg::MarkerHi);
  assign is_soi    = (hi == jfbs_pkg::SoiCode) && (len >= jfbs_pkg::SoiNextLo);
  assign has_len   = (hi < jfbs_pkg::NoLenLo) || (hi > jfbs_pkg::NoLenHi);

  // skip count, zero when absent or at or over the limit inside a frame
  always_comb begin
    count = (len != 16'd0) ? len - 16'd1 : 16'd0;
    if (open_q && (count >= max_seg_i)) begin
      count = 16'd0;
    end
  end

  // next state for one byte
  always_comb begin
    window_d = window_q;
    open_d   = open_q;
    skip_d   = skip_q;
    boundary = 1'b0;
    skipping = 1'b0;
    if (!item_i.end_of_stream) begin
      if (skip_q != 16'd0) begin
        skip_d   = skip_q - 16'd1;
        window_d = '0;
        skipping = 1'b1;
      end else begin
        window_d = shifted;
        if (is_marker) begin
          if (is_soi) begin
            boundary = open_q;
            open_d   = 1'b1;
          end else if (has_len && (count != 16'd0)) begin
            skip_d   = count - 16'd1;
            window_d = '0;
          end
        end
      end
    end
  end

  assign result_o.frame_boundary = boundary;
  assign result_o.in_frame       = open_d;
  assign result_o.skipping       = skipping;

  // state update on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      open_q   <= 1'b0;
      skip_q   <= '0;
    end else if (step_i) begin
      window_q <= window_d;
      open_q   <= open_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== sv/jpeg_frame_boundary_scanner.sv =====
// Scans a jpeg / mjpeg byte stream and flags where each new frame begins.
// Input channel: in_valid_i / in_stall_o with in_data_i (one byte, or an
// end-of-stream marker). Output channel: out_valid_o / out_stall_i with
// out_data_o, one result for every input transfer, in order.
// Configuration: cfg_valid_i / cfg_ready_o carry the maximum segment length;
// ready is always high, and writes belong while the block is idle.
// From the input transfer to the result being shown, the byte first lands in
// the input register, then the scan logic updates its window, frame flag and
// skip counter and loads the result register. Throughput is one byte per
// cycle while the receiver does not stall; the next byte's scan depends only
// on the state left by the previous byte.
// When the receiver stalls, the result register holds its value, the input
// register fills, and in_stall_o rises until the result is taken.
// Reset clears the window, frame flag, skip counter and both valid flags,
// and sets the maximum segment length to 61440.
module jpeg_frame_boundary_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jfbs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jfbs_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);

  logic                in_valid_q;
  jfbs_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  jfbs_pkg::out_item_t out_item_q;
  jfbs_pkg::out_item_t result;
  logic [15:0]         max_seg_q;
  logic                advance, step, in_xfer;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_data_i;
    end
  end

  // scan logic and state
  jfbs_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .max_seg_i (max_seg_q),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_item_q <= result;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q <= jfbs_pkg::MaxSegReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_seg_q <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// ===== sv/jfbs_checker.sv =====
// port-level checks for the jpeg frame boundary scanner, bound to the top level
module jfbs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input jfbs_pkg::out_item_t out_data_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // a boundary is only reported inside an open frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_boundary |-> out_data_o.in_frame)
    else $error("boundary outside a frame");

  // a payload byte never marks a boundary
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.skipping |-> !out_data_o.frame_boundary)
    else $error("boundary on a skipped byte");

  // once open, a frame stays open for the following results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.in_frame
      |=> !out_valid_o || out_data_o.in_frame)
    else $error("frame closed");

endmodule

bind jpeg_frame_boundary_scanner jfbs_checker u_jfbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== verif/tb_jpeg_frame_boundary_scanner.sv =====
// testbench for the jpeg frame boundary scanner: directed cases and random jpeg-like streams checked per byte
`timescale 1ns / 100ps

module tb_jpeg_frame_boundary_scanner;

  // marker prefix, marker second bytes and stuffing used to build streams
  localparam logic [7:0] MarkPrefix = 8'hFF;
  localparam logic [7:0] MarkSoi    = 8'hD8;
  localparam logic [7:0] MarkEoi    = 8'hD9;
  localparam logic [7:0] MarkRst0   = 8'hD0;
  localparam logic [7:0] MarkSos    = 8'hDA;
  localparam logic [7:0] MarkSof0   = 8'hC0;
  localparam logic [7:0] MarkDqt    = 8'hDB;
  localparam logic [7:0] MarkApp0   = 8'hE0;
  localparam logic [7:0] MarkCom    = 8'hFE;
  localparam logic [7:0] Stuffing   = 8'h00;

  localparam int unsigned PhaseItems = 330;
  localparam int unsigned IdleLimit  = 4000;

  // expected-flag predictor and checker
  class frame_scan_scoreboard;
    logic [31:0]          window;
    logic                 frame_open;
    logic [15:0]          skip_left;
    logic [15:0]          seg_limit;
    jfbs_pkg::out_item_t  expected_flags_q[$];
    int                   errors;

    function new();
      window     = '0;
      frame_open = 1'b0;
      skip_left  = '0;
      seg_limit  = jfbs_pkg::MaxSegReset;
      errors     = 0;
    endfunction

    function void set_limit(logic [15:0] value);
      seg_limit = value;
    endfunction

    function int pending();
      return expected_flags_q.size();
    endfunction

    // advance the scan state by one transfer and queue its flags
    function void note_byte(jfbs_pkg::in_item_t it);
      jfbs_pkg::out_item_t want;
      logic [31:0]         w;
      int unsigned         seg_len;
      int unsigned         count;
      want = '0;
      if (it.end_of_stream) begin
        want.in_frame = frame_open;
      end else if (skip_left != 0) begin
        // segment payload passes unseen
        skip_left = skip_left - 16'd1;
        window = '0;
        want.skipping = 1'b1;
        want.in_frame = frame_open;
      end else begin
        w = {window[23:0], it.byte_in};
        window = w;
        if (w[31:16] >= jfbs_pkg::MarkerLo && w[31:16] <= jfbs_pkg::MarkerHi) begin
          if (w[31:16] == jfbs_pkg::SoiCode && w[15:0] >= jfbs_pkg::SoiNextLo) begin
            // soi plus marker: a new frame, boundary if one is already open
            want.frame_boundary = frame_open;
            frame_open = 1'b1;
          end else if (w[31:16] < jfbs_pkg::NoLenLo || w[31:16] > jfbs_pkg::NoLenHi) begin
            // marker with a length field
            seg_len = w[15:0];
            count = (seg_len > 0) ? seg_len - 1 : 0;
            if (frame_open && count >= seg_limit) count = 0;
            if (count > 0) begin
              skip_left = 16'(count - 1);
              window = '0;
            end
          end
        end
        want.in_frame = frame_open;
      end
      expected_flags_q.push_back(want);
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // compare one result transfer against the oldest expectation
    task check_flags(jfbs_pkg::out_item_t got);
      jfbs_pkg::out_item_t want;
      if (expected_flags_q.size() == 0) begin
        report("result transfer with no byte pending");
        return;
      end
      want = expected_flags_q.pop_front();
      if (got.frame_boundary !== want.frame_boundary)
        report($sformatf("frame_boundary got %b want %b", got.frame_boundary,
                         want.frame_boundary));
      if (got.in_frame !== want.in_frame)
        report($sformatf("in_frame got %b want %b", got.in_frame, want.in_frame));
      if (got.skipping !== want.skipping)
        report($sformatf("skipping got %b want %b", got.skipping, want.skipping));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  jfbs_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  jfbs_pkg::out_item_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [15:0]         cfg_data_i = '0;

  frame_scan_scoreboard flags_sb;
  logic [15:0] seg_limit_now = jfbs_pkg::MaxSegReset;
  int unsigned burst_left = 0;
  int unsigned phase_count = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  stall_tick = '0;
  logic [1:0]  stall_mode = '0;

  jpeg_frame_boundary_scanner u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // receiver stall pattern, mode redrawn at random when the stall tick's low bits wrap to zero
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_tick[2] & stall_tick[1];
    endcase
  end

  // transfer monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) flags_sb.set_limit(cfg_data_i);
      if (in_valid_i && !in_stall_o) flags_sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) flags_sb.check_flags(out_data_o);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // drop valid and wait until every expected result has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (flags_sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    seg_limit_now = value;
  endtask

  // one input transfer, with bursts, gaps and the odd full drain
  task automatic push_item(jfbs_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 19) == 0) begin
        settle();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    phase_count++;
  endtask

  task automatic send_byte(logic [7:0] value);
    jfbs_pkg::in_item_t it;
    it.byte_in = value;
    it.end_of_stream = 1'b0;
    push_item(it);
  endtask

  task automatic send_eos();
    jfbs_pkg::in_item_t it;
    it.byte_in = 8'($urandom_range(0, 255));
    it.end_of_stream = 1'b1;
    push_item(it);
  endtask

  // marker segment with a length that is normal, tiny, long or near the limit
  task automatic send_segment(logic [7:0] mark);
    int unsigned r;
    int unsigned seg_len;
    int unsigned count;
    int unsigned body;
    logic        skipped;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      seg_len = $urandom_range(0, 1);
    end else if (r <= 2) begin
      if (seg_limit_now <= 16'd64) seg_len = seg_limit_now + $urandom_range(0, 2);
      else if (seg_limit_now <= 16'hFFFC) seg_len = seg_limit_now + $urandom_range(1, 3);
      else seg_len = 2 + $urandom_range(0, 22);
    end else if (r == 3) begin
      seg_len = 2 + $urandom_range(23, 300);
    end else begin
      seg_len = 2 + $urandom_range(0, 22);
    end
    count = (seg_len > 0) ? seg_len - 1 : 0;
    skipped = (count > 0) && (count < seg_limit_now);
    body = skipped ? seg_len - 2 : $urandom_range(0, 6);
    send_byte(MarkPrefix);
    send_byte(mark);
    send_byte(seg_len[15:8]);
    send_byte(seg_len[7:0]);
    // scanned bodies avoid marker prefixes to keep skips bounded
    repeat (body) send_byte(8'($urandom_range(0, skipped ? 255 : 254)));
  endtask

  // one well-formed frame with random content
  task automatic send_frame();
    int unsigned n;
    logic [7:0]  b;
    if ($urandom_range(0, 7) == 0) send_byte(MarkPrefix);
    send_byte(MarkPrefix);
    send_byte(MarkSoi);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 4))
        0: send_segment(MarkSof0 + 8'($urandom_range(0, 15)));
        1: send_segment(MarkDqt + 8'($urandom_range(0, 4)));
        2: send_segment(MarkApp0 + 8'($urandom_range(0, 15)));
        3: send_segment(MarkCom);
        default: send_segment(MarkApp0);
      endcase
    end
    send_segment(MarkSos);
    // entropy-coded data with stuffing and restart markers
    n = $urandom_range(0, 40);
    repeat (n) begin
      if ($urandom_range(0, 31) == 0) begin
        send_byte(MarkPrefix);
        send_byte(MarkRst0 + 8'($urandom_range(0, 7)));
      end else begin
        b = 8'($urandom_range(0, 255));
        send_byte(b);
        if (b == MarkPrefix) send_byte(Stuffing);
      end
    end
    if ($urandom_range(0, 19) < 17) begin
      send_byte(MarkPrefix);
      send_byte(MarkEoi);
    end
    if ($urandom_range(0, 9) == 0) send_eos();
  endtask

  // short run of junk bytes
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b);
      if (b == MarkPrefix)
        send_byte(($urandom_range(0, 1) == 0) ? Stuffing : MarkRst0 + 8'($urandom_range(0, 9)));
    end
  endtask

  // truncated frame starts and fill bytes
  task automatic send_broken();
    case ($urandom_range(0, 2))
      0: begin
        send_byte(MarkPrefix);
        send_byte(MarkSoi);
      end
      1: begin
        send_byte(MarkPrefix);
        send_byte(MarkSoi);
        send_byte(MarkPrefix);
        send_byte(MarkApp0);
        send_byte(8'h00);
      end
      default: repeat (3) send_byte(MarkPrefix);
    endcase
  endtask

  logic [15:0] phase_limits[5];

  initial begin
    flags_sb = new();
    phase_limits = '{16'd0, 16'hFFFF, 16'd16, 16'd3, 16'hF000};
    phase_limits[3] = 16'($urandom_range(3, 40));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: end of stream with no frame, a short segment outside a frame
    send_eos();
    send_byte(8'h00);
    send_byte(MarkPrefix);
    send_byte(8'hC4);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h11);
    send_byte(8'h22);
    // outside a frame the length limit does not apply
    settle();
    write_limit(16'd2);
    send_byte(MarkPrefix);
    send_byte(8'hC4);
    send_byte(8'h00);
    send_byte(8'h05);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    // open a frame, then an oversized segment inside it is not skipped
    send_byte(MarkPrefix);
    send_byte(MarkSoi);
    send_byte(MarkPrefix);
    send_byte(MarkApp0);
    send_byte(MarkPrefix);
    send_byte(8'hC4);
    send_byte(8'h00);
    send_byte(8'h05);
    send_eos();

    // random streams under several length limits
    foreach (phase_limits[p]) begin
      settle();
      write_limit(phase_limits[p]);
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        case ($urandom_range(0, 19))
          13, 14, 15: send_noise();
          16, 17:     send_broken();
          18:         send_eos();
          default:    send_frame();
        endcase
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (flags_sb.errors == 0 && flags_sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/jfbs_pkg.sv
sv/jfbs_state.sv
sv/jpeg_frame_boundary_scanner.sv
sv/jfbs_checker.sv
verif/tb_jpeg_frame_boundary_scanner.sv
